// ===== hw/rtl/txc_pkg.sv =====
// ----------------------------------------------------------------------------
// txc_pkg
// Shared types and constants for the text console glyph renderer.
// ----------------------------------------------------------------------------
package txc_pkg;

	localparam int GLYPH_SLOTS     = 256;
	localparam int MAX_GLYPH_ROWS  = 32;
	localparam int MAX_GLYPH_WIDTH = 16;

	// Rows emitted per drawn character never exceed this many.
	localparam int ROWS_CAP = (MAX_GLYPH_ROWS < 32) ? MAX_GLYPH_ROWS : 32;

	localparam int SLOT_W  = $clog2(GLYPH_SLOTS);
	localparam int ROW_W   = $clog2(MAX_GLYPH_ROWS);
	localparam int ADDR_W  = SLOT_W + ROW_W;
	localparam int DEPTH   = 1 << ADDR_W;

	// Control characters that draw nothing.
	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_HT = 8'd9;
	localparam logic [7:0] CH_VT = 8'd11;
	localparam logic [7:0] CH_FF = 8'd12;
	localparam logic [7:0] CH_CR = 8'd13;

	// Item functions.
	localparam logic FUNC_PUTC = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd0;
	localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_GLYPH_COUNT   = 3'd2;
	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd3;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;
	localparam logic [2:0] REG_LINE_PITCH    = 3'd5;
	localparam logic [2:0] REG_FRAME_BASE    = 3'd6;

	typedef struct packed {
		logic        func;
		logic [7:0]  character;
		logic [7:0]  glyph_index;
		logic [4:0]  glyph_row;
		logic [15:0] row_bits_in;
	} item_t;

	typedef struct packed {
		logic [31:0] pixel_offset;
		logic [15:0] row_bits_out;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/text_console_glyph_renderer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text cursor, glyph store and row emitter for a bitmap font console.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | beat contents
//  ---------+----------------------+--------------------------------------------
//  item     | item_valid/stall     | put character, or load of one glyph row
//  result   | result_valid/stall   | byte address and pixels of one glyph row
//  cfg      | cfg_valid/ready      | register index and write data
//
// A glyph-row load does not stall the item channel; the block is ready again at once.
// A put character walks a small sequencer around one shared multiplier:
// a multiply and a compare per wrap check, three multiplies to build the
// row base address, one add and one store read; a control character ends
// after the wrap checks; a drawn one emits its rows at one per cycle while
// result_stall is low, paced by the single read port of the glyph store.
// A stall on the result channel holds the output register and freezes the
// row loop; the item channel is stalled for the whole put character.
// Reset clears the cursor and loads the register defaults; the glyph store
// holds nothing defined until rows are loaded into it.

module text_console_glyph_renderer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  txc_pkg::item_t      item,
	output logic                result_valid,
	input  logic                result_stall,
	output txc_pkg::result_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MCOL,
		S_CCOL,
		S_MROW,
		S_CROW,
		S_MBX,
		S_MBY,
		S_MBP,
		S_ADD,
		S_RD,
		S_WR
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [4:0]  glyph_width_q;
	logic [5:0]  glyph_height_q;
	logic [8:0]  glyph_count_q;
	logic [12:0] screen_width_q;
	logic [12:0] screen_height_q;
	logic [14:0] line_pitch_q;
	logic [31:0] frame_base_q;

	// Cursor and per-character working registers.
	logic [11:0] col_q;
	logic [11:0] row_q;
	logic [7:0]  ch_q;
	logic [txc_pkg::SLOT_W-1:0] glyph_q;
	logic [5:0]  rows_q;
	logic [5:0]  y_q;
	logic [15:0] mask_q;
	logic [31:0] acc_q;
	logic [31:0] prod_q;
	logic [15:0] rd_q;

	// Output register.
	logic             out_valid_q;
	txc_pkg::result_t out_q;

	logic [15:0] store_mem [txc_pkg::DEPTH];

	logic        accept;
	logic        out_free;
	logic        row_fire;
	logic        last_row;
	logic [5:0]  y_next;
	logic [18:0] mul_a;
	logic [14:0] mul_b;
	logic [33:0] mul_p;
	logic        rd_en;
	logic [txc_pkg::ADDR_W-1:0] rd_addr;
	logic        wr_en;
	logic [txc_pkg::ADDR_W-1:0] wr_addr;
	logic [txc_pkg::SLOT_W-1:0] glyph_sel;
	logic [5:0]  rows_sel;
	logic [15:0] mask_sel;
	logic        printable;

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// The output slot can take a new beat when it is empty or being drained.
	assign out_free = !out_valid_q || !result_stall;
	assign row_fire = (state_q == S_WR) && out_free;
	assign y_next   = y_q + 6'd1;
	assign last_row = (y_next == rows_q);

	assign printable = (ch_q != txc_pkg::CH_NL) && (ch_q != txc_pkg::CH_HT) &&
		(ch_q != txc_pkg::CH_VT) && (ch_q != txc_pkg::CH_FF) &&
		(ch_q != txc_pkg::CH_CR);

	// Glyph choice, row count and pixel mask are fixed when the item arrives.
	always_comb begin
		if (item.character == 8'd0 || item.character >= 8'd128 ||
			{1'b0, item.character} >= glyph_count_q ||
			32'(item.character) >= 32'(txc_pkg::GLYPH_SLOTS)) begin
			glyph_sel = '0;
		end else begin
			glyph_sel = item.character[txc_pkg::SLOT_W-1:0];
		end
		if (32'(glyph_height_q) > 32'(txc_pkg::ROWS_CAP)) begin
			rows_sel = 6'(txc_pkg::ROWS_CAP);
		end else begin
			rows_sel = glyph_height_q;
		end
		if (glyph_width_q >= 5'd16) begin
			mask_sel = 16'hFFFF;
		end else begin
			mask_sel = (16'd1 << glyph_width_q[3:0]) - 16'd1;
		end
	end

	// The shared multiplier: its operands follow the sequencer state.
	always_comb begin
		case (state_q)
			S_MCOL: begin
				mul_a = 19'({1'b0, col_q} + 13'd1);
				mul_b = 15'({1'b0, glyph_width_q} + 6'd1);
			end
			S_MROW: begin
				mul_a = 19'({1'b0, row_q} + 13'd1);
				mul_b = 15'({1'b0, glyph_height_q} + 7'd1);
			end
			S_MBX: begin
				mul_a = 19'(col_q);
				mul_b = 15'({1'b0, glyph_width_q} + 6'd1);
			end
			S_MBY: begin
				mul_a = 19'(row_q);
				mul_b = 15'({1'b0, glyph_height_q} + 7'd1);
			end
			S_MBP: begin
				mul_a = prod_q[18:0];
				mul_b = line_pitch_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 34'(mul_a) * 34'(mul_b);

	// Glyph store ports.
	always_comb begin
		wr_en   = accept && (item.func == txc_pkg::FUNC_LOAD) &&
			(32'(item.glyph_index) < 32'(txc_pkg::GLYPH_SLOTS)) &&
			(32'(item.glyph_row) < 32'(txc_pkg::MAX_GLYPH_ROWS));
		wr_addr = {item.glyph_index[txc_pkg::SLOT_W-1:0],
			item.glyph_row[txc_pkg::ROW_W-1:0]};
		rd_en   = (state_q == S_RD) || row_fire;
		if (state_q == S_RD) begin
			rd_addr = {glyph_q, y_q[txc_pkg::ROW_W-1:0]};
		end else begin
			rd_addr = {glyph_q, y_next[txc_pkg::ROW_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= item.row_bits_in;
		end
		if (rd_en) begin
			rd_q <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			glyph_width_q   <= 5'd8;
			glyph_height_q  <= 6'd16;
			glyph_count_q   <= 9'd256;
			screen_width_q  <= 13'd640;
			screen_height_q <= 13'd480;
			line_pitch_q    <= 15'd2560;
			frame_base_q    <= 32'd0;
			col_q           <= '0;
			row_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					txc_pkg::REG_GLYPH_WIDTH:   glyph_width_q   <= cfg_data[4:0];
					txc_pkg::REG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data[5:0];
					txc_pkg::REG_GLYPH_COUNT:   glyph_count_q   <= cfg_data[8:0];
					txc_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[12:0];
					txc_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[12:0];
					txc_pkg::REG_LINE_PITCH:    line_pitch_q    <= cfg_data[14:0];
					txc_pkg::REG_FRAME_BASE:    frame_base_q    <= cfg_data;
					default: begin
					end
				endcase
			end

			// A drained beat empties the slot unless a new row refills it.
			if (out_valid_q && !result_stall && !row_fire) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept && item.func == txc_pkg::FUNC_PUTC) begin
						ch_q    <= item.character;
						glyph_q <= glyph_sel;
						rows_q  <= rows_sel;
						mask_q  <= mask_sel;
						state_q <= S_MCOL;
					end
				end
				S_MCOL: begin
					prod_q  <= mul_p[31:0];
					state_q <= S_CCOL;
				end
				S_CCOL: begin
					// (col + 1) * cell width beyond the screen means the line is full.
					if (prod_q > 32'(screen_width_q) || ch_q == txc_pkg::CH_NL) begin
						row_q <= row_q + 12'd1;
						col_q <= '0;
					end
					state_q <= S_MROW;
				end
				S_MROW: begin
					prod_q  <= mul_p[31:0];
					state_q <= S_CROW;
				end
				S_CROW: begin
					if (prod_q > 32'(screen_height_q)) begin
						row_q <= '0;
						col_q <= '0;
					end
					state_q <= printable ? S_MBX : S_IDLE;
				end
				S_MBX: begin
					prod_q  <= mul_p[31:0];
					state_q <= S_MBY;
				end
				S_MBY: begin
					acc_q   <= frame_base_q + {prod_q[29:0], 2'b00};
					prod_q  <= mul_p[31:0];
					state_q <= S_MBP;
				end
				S_MBP: begin
					prod_q  <= mul_p[31:0];
					state_q <= S_ADD;
				end
				S_ADD: begin
					acc_q   <= acc_q + prod_q;
					col_q   <= col_q + 12'd1;
					y_q     <= '0;
					state_q <= (rows_q == 6'd0) ? S_IDLE : S_RD;
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_q.pixel_offset <= acc_q;
						out_q.row_bits_out <= rd_q & mask_q;
						out_q.last         <= last_row;
						acc_q              <= acc_q + 32'(line_pitch_q);
						y_q                <= y_next;
						if (last_row) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/txc_checker.sv =====
// ----------------------------------------------------------------------------
// txc_checker
// Port-level checks for the text console glyph renderer.
// ----------------------------------------------------------------------------
module txc_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  txc_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  txc_pkg::result_t result,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	// A stalled result beat stays and keeps its contents.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// A put character keeps the item channel busy while it is worked on.
	a_putc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.func == txc_pkg::FUNC_PUTC |=> item_stall)
		else $error("item taken during a put character");

	// A glyph-row load leaves the item channel ready for the next item.
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.func == txc_pkg::FUNC_LOAD |=> !item_stall)
		else $error("glyph-row load held the item channel");

	// While the block is idle no new result beat can appear.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!item_stall && !result_valid ##1 !item_stall |-> !result_valid)
		else $error("result beat appeared with no character in work");

	// Configuration writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind text_console_glyph_renderer_top txc_checker u_txc_checker (.*);
